// File: rtl/e2q_pkg.sv
// Package for the Euler angle to quaternion unit.
// Holds the CORDIC angle table, fixed-point constants and widths.
// Depends on nothing.
package e2q_pkg;

    localparam int TRIG_STAGES_DEFAULT = 16;
    localparam int TABLE_LEN = 24;
    localparam int ANGLE_W = 16;
    localparam int Z_W = 34;
    localparam int XY_W = 34;
    localparam int TRIG_W = 22;
    localparam int Q_W = 16;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd23040;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q20 = 22'sd1048576;

    function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] idx);
        logic signed [Z_W-1:0] r;
        begin
            unique case (idx)
                5'd0: r = 34'sd754974720;
                5'd1: r = 34'sd445687602;
                5'd2: r = 34'sd235489088;
                5'd3: r = 34'sd119537938;
                5'd4: r = 34'sd60000934;
                5'd5: r = 34'sd30029717;
                5'd6: r = 34'sd15018523;
                5'd7: r = 34'sd7509720;
                5'd8: r = 34'sd3754917;
                5'd9: r = 34'sd1877466;
                5'd10: r = 34'sd938734;
                5'd11: r = 34'sd469367;
                5'd12: r = 34'sd234684;
                5'd13: r = 34'sd117342;
                5'd14: r = 34'sd58671;
                5'd15: r = 34'sd29335;
                5'd16: r = 34'sd14668;
                5'd17: r = 34'sd7334;
                5'd18: r = 34'sd3667;
                5'd19: r = 34'sd1833;
                5'd20: r = 34'sd917;
                5'd21: r = 34'sd458;
                5'd22: r = 34'sd229;
                5'd23: r = 34'sd115;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/e2q_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of half an angle.
// One register stage per iteration. Depends on e2q_pkg.
module e2q_cordic #(
    parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  angle,
    output logic                                out_valid,
    output logic signed [e2q_pkg::TRIG_W-1:0]   sin_val,
    output logic signed [e2q_pkg::TRIG_W-1:0]   cos_val
);
    localparam int N = (TRIG_STAGES < e2q_pkg::TABLE_LEN) ? TRIG_STAGES : e2q_pkg::TABLE_LEN;
    localparam int XW = e2q_pkg::XY_W;
    localparam int ZW = e2q_pkg::Z_W;

    logic                  v_reg [0:N];
    logic signed [XW-1:0]  x_reg [0:N];
    logic signed [XW-1:0]  y_reg [0:N];
    logic signed [ZW-1:0]  z_reg [0:N];
    logic signed [e2q_pkg::ANGLE_W-1:0] a_clamp;
    logic signed [XW-1:0] cr;
    logic signed [XW-1:0] sr;

    always_comb
    begin
        if (angle > e2q_pkg::ANGLE_LIMIT)
            a_clamp = e2q_pkg::ANGLE_LIMIT;
        else if (angle < -e2q_pkg::ANGLE_LIMIT)
            a_clamp = -e2q_pkg::ANGLE_LIMIT;
        else
            a_clamp = angle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= e2q_pkg::CORDIC_GAIN;
        y_reg[0] <= '0;
        z_reg[0] <= {{(ZW-ZW+2){a_clamp[e2q_pkg::ANGLE_W-1]}}, a_clamp, 16'd0};
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (!z_reg[i][ZW-1])
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                z_reg[i+1] <= z_reg[i] - e2q_pkg::atan_deg(5'(i));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                z_reg[i+1] <= z_reg[i] + e2q_pkg::atan_deg(5'(i));
            end
        end
    end

    assign cr = (x_reg[N] + XW'(512)) >>> 10;
    assign sr = (y_reg[N] + XW'(512)) >>> 10;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= v_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (cr > XW'(e2q_pkg::ONE_Q20))
            cos_val <= e2q_pkg::ONE_Q20;
        else if (cr < -XW'(e2q_pkg::ONE_Q20))
            cos_val <= -e2q_pkg::ONE_Q20;
        else
            cos_val <= cr[e2q_pkg::TRIG_W-1:0];
        if (sr > XW'(e2q_pkg::ONE_Q20))
            sin_val <= e2q_pkg::ONE_Q20;
        else if (sr < -XW'(e2q_pkg::ONE_Q20))
            sin_val <= -e2q_pkg::ONE_Q20;
        else
            sin_val <= sr[e2q_pkg::TRIG_W-1:0];
    end
endmodule

// File: rtl/e2q_combine.sv
// Pipelined triple-product combiner forming the four quaternion components.
// Pair products, split partial products, partial sums, then merging and rounding.
// Depends on e2q_pkg.
module e2q_combine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               valid,
    input  logic signed [e2q_pkg::TRIG_W-1:0]  sr,
    input  logic signed [e2q_pkg::TRIG_W-1:0]  cr,
    input  logic signed [e2q_pkg::TRIG_W-1:0]  sp,
    input  logic signed [e2q_pkg::TRIG_W-1:0]  cp,
    input  logic signed [e2q_pkg::TRIG_W-1:0]  sy,
    input  logic signed [e2q_pkg::TRIG_W-1:0]  cy,
    output logic                               out_valid,
    output logic signed [e2q_pkg::Q_W-1:0]     qx,
    output logic signed [e2q_pkg::Q_W-1:0]     qy,
    output logic signed [e2q_pkg::Q_W-1:0]     qz,
    output logic signed [e2q_pkg::Q_W-1:0]     qw
);
    localparam int PW = 2 * e2q_pkg::TRIG_W;
    localparam int TW = 3 * e2q_pkg::TRIG_W;
    localparam int HW = 2 * e2q_pkg::TRIG_W;
    localparam int LW = 2 * e2q_pkg::TRIG_W + 1;
    localparam logic signed [TW-1:0] RND_BIAS = TW'(1) <<< 44;

    logic [3:0] v_reg;
    logic signed [PW-1:0] crsp_reg, srcp_reg, crcp_reg, srsp_reg;
    logic signed [e2q_pkg::TRIG_W-1:0] sy_reg, cy_reg;
    logic signed [PW-1:0] pair [0:7];
    logic signed [e2q_pkg::TRIG_W-1:0] trig [0:7];
    logic signed [HW-1:0] ph_reg [0:7];
    logic signed [LW-1:0] pl_reg [0:7];
    logic signed [TW-1:0] hs_reg [0:3];
    logic signed [TW-1:0] ls_reg [0:3];
    logic signed [TW-1:0] tot [0:3];
    logic signed [TW-1:0] rnd [0:3];
    logic signed [e2q_pkg::Q_W-1:0] q [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[2:0], valid};
    end

    always_ff @(posedge clk)
    begin
        crsp_reg <= cr * sp;
        srcp_reg <= sr * cp;
        crcp_reg <= cr * cp;
        srsp_reg <= sr * sp;
        sy_reg <= sy;
        cy_reg <= cy;
    end

    assign pair[0] = crsp_reg;
    assign pair[1] = srcp_reg;
    assign pair[2] = srcp_reg;
    assign pair[3] = crsp_reg;
    assign pair[4] = crcp_reg;
    assign pair[5] = srsp_reg;
    assign pair[6] = crcp_reg;
    assign pair[7] = srsp_reg;
    assign trig[0] = cy_reg;
    assign trig[1] = sy_reg;
    assign trig[2] = cy_reg;
    assign trig[3] = sy_reg;
    assign trig[4] = sy_reg;
    assign trig[5] = cy_reg;
    assign trig[6] = cy_reg;
    assign trig[7] = sy_reg;

    // Each pair product is split into a signed upper half and an unsigned lower half
    // so that each multiplier operand is at most one bit wider than the trig word.
    for (genvar j = 0; j < 8; j++) begin : g_part
        logic signed [e2q_pkg::TRIG_W-1:0] hi;
        logic signed [e2q_pkg::TRIG_W:0]   lo;
        assign hi = pair[j][PW-1:e2q_pkg::TRIG_W];
        assign lo = {1'b0, pair[j][e2q_pkg::TRIG_W-1:0]};

        always_ff @(posedge clk)
        begin
            ph_reg[j] <= hi * trig[j];
            pl_reg[j] <= lo * trig[j];
        end
    end

    always_ff @(posedge clk)
    begin
        hs_reg[0] <= TW'(ph_reg[0]) + TW'(ph_reg[1]);
        ls_reg[0] <= TW'(pl_reg[0]) + TW'(pl_reg[1]) + RND_BIAS;
        hs_reg[1] <= TW'(ph_reg[2]) - TW'(ph_reg[3]);
        ls_reg[1] <= TW'(pl_reg[2]) - TW'(pl_reg[3]) + RND_BIAS;
        hs_reg[2] <= TW'(ph_reg[4]) - TW'(ph_reg[5]);
        ls_reg[2] <= TW'(pl_reg[4]) - TW'(pl_reg[5]) + RND_BIAS;
        hs_reg[3] <= TW'(ph_reg[6]) + TW'(ph_reg[7]);
        ls_reg[3] <= TW'(pl_reg[6]) + TW'(pl_reg[7]) + RND_BIAS;
    end

    for (genvar k = 0; k < 4; k++) begin : g_rnd
        assign tot[k] = (hs_reg[k] <<< e2q_pkg::TRIG_W) + ls_reg[k];
        assign rnd[k] = tot[k] >>> 45;
        always_comb
        begin
            if (rnd[k] > TW'(32767))
                q[k] = 16'sh7fff;
            else if (rnd[k] < -TW'(32768))
                q[k] = 16'sh8000;
            else
                q[k] = rnd[k][e2q_pkg::Q_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        qx <= q[0];
        qy <= q[1];
        qz <= q[2];
        qw <= q[3];
    end

    assign out_valid = v_reg[3];
endmodule

// File: rtl/euler_to_quaternion_unit.sv
// Euler angles (Q9.7 degrees) to unit quaternion (Q1.15), fully pipelined.
// Accepts one item per cycle through CORDIC and combiner register stages.
// busy is always low; the receiver cannot stall, results appear on done for one cycle.
// Reset clears the valid pipeline only; no other state. Depends on e2q_pkg,
// e2q_cordic and e2q_combine.
module euler_to_quaternion_unit #(
    parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] roll_deg,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] pitch_deg,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] yaw_deg,
    output logic                               done,
    output logic signed [e2q_pkg::Q_W-1:0]     quat_x,
    output logic signed [e2q_pkg::Q_W-1:0]     quat_y,
    output logic signed [e2q_pkg::Q_W-1:0]     quat_z,
    output logic signed [e2q_pkg::Q_W-1:0]     quat_w
);
    logic v_r, v_p, v_y;
    logic signed [e2q_pkg::TRIG_W-1:0] sr, cr, sp, cp, sy, cy;

    assign busy = 1'b0;

    e2q_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_roll (
        .clk(clk), .rst_n(rst_n), .valid(start), .angle(roll_deg),
        .out_valid(v_r), .sin_val(sr), .cos_val(cr)
    );
    e2q_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_pitch (
        .clk(clk), .rst_n(rst_n), .valid(start), .angle(pitch_deg),
        .out_valid(v_p), .sin_val(sp), .cos_val(cp)
    );
    e2q_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_yaw (
        .clk(clk), .rst_n(rst_n), .valid(start), .angle(yaw_deg),
        .out_valid(v_y), .sin_val(sy), .cos_val(cy)
    );

    e2q_combine u_comb (
        .clk(clk), .rst_n(rst_n), .valid(v_r & v_p & v_y),
        .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
        .out_valid(done), .qx(quat_x), .qy(quat_y), .qz(quat_z), .qw(quat_w)
    );
endmodule

// File: bench/tb_euler_to_quaternion_unit.sv
// Self-checking testbench for the Euler angle to quaternion unit.
// Predicts each quaternion with a CORDIC model that shares the e2q_pkg table; checks every beat.
// Depends on e2q_pkg and euler_to_quaternion_unit.
class quat_scoreboard;
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } quat_t;

    quat_t pending[$];
    int errors;
    int stages;

    function new(int n);
        stages = n;
        errors = 0;
    endfunction

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint lim(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void half_trig(logic signed [15:0] ang, output longint s,
                                      output longint c);
        longint a;
        longint z;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        a = lim(longint'(ang), -23040, 23040);
        z = a * 65536;
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < stages && i < 24; i++)
        begin
            dx = shr(cy, i);
            dy = shr(cx, i);
            if (z >= 0)
            begin
                cx -= dx; cy += dy; z -= longint'(e2q_pkg::atan_deg(i[4:0]));
            end
            else
            begin
                cx += dx; cy -= dy; z += longint'(e2q_pkg::atan_deg(i[4:0]));
            end
        end
        c = lim(shr(cx + 512, 10), -1048576, 1048576);
        s = lim(shr(cy + 512, 10), -1048576, 1048576);
    endfunction

    function automatic logic signed [15:0] round_q15(longint v);
        return 16'(lim(shr(v + (64'sd1 <<< 44), 45), -32768, 32767));
    endfunction

    function void note_angles(logic signed [15:0] r, logic signed [15:0] p,
                              logic signed [15:0] yw);
        longint sr, cr, sp, cp, sy, cy;
        quat_t q;
        half_trig(r, sr, cr);
        half_trig(p, sp, cp);
        half_trig(yw, sy, cy);
        q.x = round_q15(cr * sp * cy + sr * cp * sy);
        q.y = round_q15(sr * cp * cy - cr * sp * sy);
        q.z = round_q15(cr * cp * sy - sr * sp * cy);
        q.w = round_q15(cr * cp * cy + sr * sp * sy);
        pending.push_back(q);
    endfunction

    function void check_quat(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic signed [15:0] w);
        quat_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected beat x=%0d y=%0d z=%0d w=%0d", $time, x, y, z, w);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (x !== e.x) begin $display("%0t: quat_x expected %0d got %0d", $time, e.x, x); errors++; end
        if (y !== e.y) begin $display("%0t: quat_y expected %0d got %0d", $time, e.y, y); errors++; end
        if (z !== e.z) begin $display("%0t: quat_z expected %0d got %0d", $time, e.z, z); errors++; end
        if (w !== e.w) begin $display("%0t: quat_w expected %0d got %0d", $time, e.w, w); errors++; end
    endfunction
endclass

module tb_euler_to_quaternion_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = e2q_pkg::TRIG_STAGES_DEFAULT;
    localparam int LATENCY = (STAGES < 24 ? STAGES : 24) + 6;
    localparam int WATCHDOG = 5000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic done;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    quat_scoreboard board;
    int idle_cycles;
    bit timed_out;

    euler_to_quaternion_unit #(.TRIG_STAGES(STAGES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .roll_deg(roll_deg), .pitch_deg(pitch_deg), .yaw_deg(yaw_deg),
        .done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        board = new(STAGES);
        timed_out = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_angles(roll_deg, pitch_deg, yaw_deg);
            if (done)
                board.check_quat(quat_x, quat_y, quat_z, quat_w);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
        else
            idle_cycles <= 0;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_angle();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return 16'($urandom);
        if (k == 1)
            return 16'($urandom_range(0, 8)) - 16'sd4 + ($urandom_range(0, 1) ? 16'sd23040 : -16'sd23040);
        return 16'(int'($urandom_range(0, 46080)) - 23040);
    endfunction

    task automatic send_beat(logic signed [15:0] r, logic signed [15:0] p,
                             logic signed [15:0] yw);
        roll_deg <= r;
        pitch_deg <= p;
        yaw_deg <= yw;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_gap();
        int n;
        int k;
        k = $urandom_range(0, 99);
        if (k < 50)
            n = 0;
        else if (k < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 60);
        if (n > 0)
        begin
            start <= 1'b0;
            roll_deg <= 16'($urandom);
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic signed [15:0] corners[8];
        corners = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd32767, -16'sd32768,
                    16'sd11520, -16'sd11520, 16'sd1};
        rst_n = 1'b0;
        start = 1'b0;
        roll_deg = '0;
        pitch_deg = '0;
        yaw_deg = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int i = 0; i < 8; i++)
            send_beat(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
        for (int i = 0; i < 8; i++)
        begin
            send_beat(corners[i], 16'sd0, 16'sd0);
            send_beat(16'sd0, corners[i], 16'sd0);
        end
        drain();
        for (int n = 0; n < 1530; n++)
        begin
            if (n == 700)
                drain();
            send_beat(rand_angle(), rand_angle(), rand_angle());
            if (n > 300)
                idle_gap();
        end
        drain();
        repeat (LATENCY + 10) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: filelist.f
rtl/e2q_pkg.sv
rtl/e2q_cordic.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion_unit.sv
bench/tb_euler_to_quaternion_unit.sv
